@@ hw/rtl/mpas_pkg.sv @@
`default_nettype none

package mpas_pkg;

   localparam int DEF_MAX_COLS    = 4096;
   localparam int DEF_SAMPLE_BITS = 16;
   localparam int DEF_INDEX_BITS  = 32;
   localparam int DEF_MAX_POOL    = 16;

   localparam int POOL_REG_W   = 5;
   localparam int DIM_REG_W    = 13;
   localparam int CHAN_REG_W   = 9;
   localparam int CHAN_W       = 8;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 3;
   localparam int MAX_CHANNELS = 256;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_POOL_ROWS        = 3'd0;
   localparam csr_index_type CSR_POOL_COLS        = 3'd1;
   localparam csr_index_type CSR_COLS_PER_ROW     = 3'd2;
   localparam csr_index_type CSR_ROWS_PER_CHANNEL = 3'd3;
   localparam csr_index_type CSR_CHANNEL_COUNT    = 3'd4;

   localparam logic [POOL_REG_W-1:0] RST_POOL = 5'd2;
   localparam logic [DIM_REG_W-1:0]  RST_DIM  = 13'd4096;
   localparam logic [CHAN_REG_W-1:0] RST_CHAN = 9'd1;

   typedef enum logic {
      ST_RUN,
      ST_DIV
   } state_type;

endpackage

`default_nettype wire

@@ hw/rtl/mpas_if.sv @@
`default_nettype none

interface mpas_req_if #(
   parameter int SAMPLE_BITS = mpas_pkg::DEF_SAMPLE_BITS
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface mpas_rsp_if #(
   parameter int SAMPLE_BITS = mpas_pkg::DEF_SAMPLE_BITS,
   parameter int INDEX_BITS  = mpas_pkg::DEF_INDEX_BITS
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] max_value;
   logic        [INDEX_BITS-1:0]  max_index;
   logic                          frame_end;

   modport source (output valid, output max_value, output max_index, output frame_end,
                   input ready);
   modport sink   (input valid, input max_value, input max_index, input frame_end,
                   output ready);
endinterface

`default_nettype wire

@@ hw/rtl/max_pool_argmax_stream_unit.sv @@
// Streaming 2-D max pooling with argmax.
// req_chan carries one signed Q8.8 sample per request in raster order: channel, then row,
// then column fastest. rsp_chan carries one result per completed pool window: the
// maximum, the flat frame index of its first occurrence and a frame_end flag on the
// last window of the frame. Leftover rows and columns are consumed silently.
// csr_* writes the five geometry registers, one per cycle; the user must do so only
// while the unit is idle, which the unit does not enforce. Throughput: one request per
// cycle while req ready is high. Running maxima live in a line store, one entry per window
// column, read and written back through a two-stage pipeline with forwarding; a result is
// registered in stage 1, then in the output buffer. After each register write the unit
// realigns its window counters with a bit-serial divider; req ready is low then.
// Reset restores the register defaults and zeroes all counters; the line store is not
// cleared, each window loads its entry from its own first sample.
// A two-entry output buffer absorbs a stalled receiver; it drops req ready only when both
// entries are full and another window completes.
`default_nettype none

module max_pool_argmax_stream_unit #(
   parameter int MAX_COLS    = mpas_pkg::DEF_MAX_COLS,
   parameter int SAMPLE_BITS = mpas_pkg::DEF_SAMPLE_BITS,
   parameter int INDEX_BITS  = mpas_pkg::DEF_INDEX_BITS,
   parameter int MAX_POOL    = mpas_pkg::DEF_MAX_POOL
) (
   input  logic                              clock,
   input  logic                              reset,
   mpas_req_if.sink                          req_chan,
   mpas_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  mpas_pkg::csr_index_type           csr_index,
   input  logic [mpas_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import mpas_pkg::*;

   localparam int CNT_W   = $clog2(MAX_COLS);
   localparam int LIM_W   = $clog2(MAX_COLS + 1);
   localparam int PW      = $clog2(MAX_POOL + 1);
   localparam int CLW     = (LIM_W > DIM_REG_W) ? LIM_W : DIM_REG_W;
   localparam int PLW     = (PW > POOL_REG_W) ? PW : POOL_REG_W;
   localparam int SUM_W   = ((LIM_W > PW + 1) ? LIM_W : PW + 1) + 1;
   localparam int DSTEP_W = $clog2(CNT_W + 1);
   localparam int MEM_W   = SAMPLE_BITS + INDEX_BITS;

   // configuration registers
   logic [POOL_REG_W-1:0] pool_rows_ff, pool_cols_ff;
   logic [DIM_REG_W-1:0]  cols_per_row_ff, rows_per_channel_ff;
   logic [CHAN_REG_W-1:0] channel_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_rows_ff        <= RST_POOL;
         pool_cols_ff        <= RST_POOL;
         cols_per_row_ff     <= RST_DIM;
         rows_per_channel_ff <= RST_DIM;
         channel_count_ff    <= RST_CHAN;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_POOL_ROWS:        pool_rows_ff        <= csr_wr_data[POOL_REG_W-1:0];
            CSR_POOL_COLS:        pool_cols_ff        <= csr_wr_data[POOL_REG_W-1:0];
            CSR_COLS_PER_ROW:     cols_per_row_ff     <= csr_wr_data[DIM_REG_W-1:0];
            CSR_ROWS_PER_CHANNEL: rows_per_channel_ff <= csr_wr_data[DIM_REG_W-1:0];
            CSR_CHANNEL_COUNT:    channel_count_ff    <= csr_wr_data[CHAN_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // effective limits, zero taken as one, saturated at the top
   logic [CLW-1:0]        cols_x, rows_x;
   logic [PLW-1:0]        prow_x, pcol_x;
   logic [LIM_W-1:0]      nc, nr;
   logic [PW-1:0]         pc, pr;
   logic [CHAN_REG_W-1:0] nch;

   assign cols_x = CLW'(cols_per_row_ff);
   assign rows_x = CLW'(rows_per_channel_ff);
   assign pcol_x = PLW'(pool_cols_ff);
   assign prow_x = PLW'(pool_rows_ff);

   assign nc = (cols_x == '0) ? LIM_W'(1) :
               (cols_x > CLW'(MAX_COLS)) ? LIM_W'(MAX_COLS) : LIM_W'(cols_x);
   assign nr = (rows_x == '0) ? LIM_W'(1) :
               (rows_x > CLW'(MAX_COLS)) ? LIM_W'(MAX_COLS) : LIM_W'(rows_x);
   assign pc = (pcol_x == '0) ? PW'(1) :
               (pcol_x > PLW'(MAX_POOL)) ? PW'(MAX_POOL) : PW'(pcol_x);
   assign pr = (prow_x == '0) ? PW'(1) :
               (prow_x > PLW'(MAX_POOL)) ? PW'(MAX_POOL) : PW'(prow_x);
   assign nch = (channel_count_ff == '0) ? CHAN_REG_W'(1) :
                (channel_count_ff > CHAN_REG_W'(MAX_CHANNELS)) ? CHAN_REG_W'(MAX_CHANNELS) :
                channel_count_ff;

   // state machine
   state_type            state_ff, state_in;
   logic [DSTEP_W-1:0]   dcnt_ff, dcnt_in;
   logic                 div_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      div_last = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            if (csr_wr_en) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (csr_wr_en) begin
               state_in = ST_DIV;
            end else if (dcnt_ff == DSTEP_W'(1)) begin
               state_in = ST_RUN;
               div_last = 1'b1;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   // counters
   logic [CNT_W-1:0]      col_ff, col_in, row_ff, row_in;
   logic [CNT_W-1:0]      col_base_ff, col_base_in, row_base_ff, row_base_in;
   logic [CNT_W-1:0]      wcol_ff, wcol_in;
   logic [PW-1:0]         v_ff, v_in, u_ff, u_in;
   logic [CHAN_W-1:0]     chan_ff, chan_in;
   logic [INDEX_BITS-1:0] flat_ff, flat_in;

   // bit-serial divide for realignment after a register write
   logic [CNT_W-1:0]      dcol_sh_ff, dcol_sh_in, drow_sh_ff, drow_sh_in;
   logic [PW-1:0]         drem_col_ff, drem_col_in, drem_row_ff, drem_row_in;
   logic [PW:0]           trial_col, trial_row;
   logic [PW-1:0]         rem_col, rem_row;
   logic                  q_col;

   // stage 0 decode
   logic [SUM_W-1:0] col_end, row_end;
   logic             col_ok, col_last, row_ok, row_last, chan_last, win_ok;
   logic             v_end, u_end, first_s0, emit_s0, last_s0;
   logic             col_wrap, row_wrap, chan_wrap;
   logic             req_fire, rd_en, stall;

   assign col_end   = SUM_W'(col_base_ff) + SUM_W'(pc);
   assign row_end   = SUM_W'(row_base_ff) + SUM_W'(pr);
   assign col_ok    = col_end <= SUM_W'(nc);
   assign row_ok    = row_end <= SUM_W'(nr);
   assign col_last  = (col_end + SUM_W'(pc)) > SUM_W'(nc);
   assign row_last  = (row_end + SUM_W'(pr)) > SUM_W'(nr);
   assign chan_last = (CHAN_REG_W'(chan_ff) + CHAN_REG_W'(1)) == nch;
   assign chan_wrap = (CHAN_REG_W'(chan_ff) + CHAN_REG_W'(1)) >= nch;
   assign col_wrap  = (SUM_W'(col_ff) + SUM_W'(1)) >= SUM_W'(nc);
   assign row_wrap  = (SUM_W'(row_ff) + SUM_W'(1)) >= SUM_W'(nr);
   assign v_end     = ((PW+1)'(v_ff) + (PW+1)'(1)) == (PW+1)'(pc);
   assign u_end     = ((PW+1)'(u_ff) + (PW+1)'(1)) == (PW+1)'(pr);
   assign win_ok    = col_ok && row_ok;
   assign first_s0  = (u_ff == '0) && (v_ff == '0);
   assign emit_s0   = win_ok && u_end && v_end;
   assign last_s0   = chan_last && row_last && col_last;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign rd_en     = req_fire && win_ok;

   assign trial_col = {drem_col_ff, dcol_sh_ff[CNT_W-1]};
   assign trial_row = {drem_row_ff, drow_sh_ff[CNT_W-1]};
   assign q_col     = trial_col >= (PW+1)'(pc);
   assign rem_col   = q_col ? PW'(trial_col - (PW+1)'(pc)) : PW'(trial_col);
   assign rem_row   = (trial_row >= (PW+1)'(pr)) ? PW'(trial_row - (PW+1)'(pr)) : PW'(trial_row);

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      col_base_in = col_base_ff;
      row_base_in = row_base_ff;
      wcol_in     = wcol_ff;
      v_in        = v_ff;
      u_in        = u_ff;
      chan_in     = chan_ff;
      flat_in     = flat_ff;
      dcnt_in     = dcnt_ff;
      dcol_sh_in  = dcol_sh_ff;
      drow_sh_in  = drow_sh_ff;
      drem_col_in = drem_col_ff;
      drem_row_in = drem_row_ff;
      priority if (csr_wr_en) begin
         dcnt_in     = DSTEP_W'(CNT_W);
         dcol_sh_in  = col_ff;
         drow_sh_in  = row_ff;
         drem_col_in = '0;
         drem_row_in = '0;
      end else if (state_ff == ST_DIV) begin
         dcnt_in     = dcnt_ff - DSTEP_W'(1);
         dcol_sh_in  = {dcol_sh_ff[CNT_W-2:0], q_col};
         drow_sh_in  = drow_sh_ff << 1;
         drem_col_in = rem_col;
         drem_row_in = rem_row;
         if (div_last) begin
            v_in        = rem_col;
            u_in        = rem_row;
            wcol_in     = {dcol_sh_ff[CNT_W-2:0], q_col};
            col_base_in = col_ff - CNT_W'(rem_col);
            row_base_in = row_ff - CNT_W'(rem_row);
         end
      end else if (req_fire) begin
         flat_in = flat_ff + INDEX_BITS'(1);
         if (col_wrap) begin
            col_in      = '0;
            v_in        = '0;
            col_base_in = '0;
            wcol_in     = '0;
            if (row_wrap) begin
               row_in      = '0;
               u_in        = '0;
               row_base_in = '0;
               if (chan_wrap) begin
                  chan_in = '0;
                  flat_in = '0;
               end else begin
                  chan_in = chan_ff + CHAN_W'(1);
               end
            end else begin
               row_in = row_ff + CNT_W'(1);
               if (u_end) begin
                  u_in        = '0;
                  row_base_in = row_base_ff + CNT_W'(pr);
               end else begin
                  u_in = u_ff + PW'(1);
               end
            end
         end else begin
            col_in = col_ff + CNT_W'(1);
            if (v_end) begin
               v_in        = '0;
               col_base_in = col_base_ff + CNT_W'(pc);
               wcol_in     = wcol_ff + CNT_W'(1);
            end else begin
               v_in = v_ff + PW'(1);
            end
         end
      end else begin
         // hold
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         col_base_ff <= '0;
         row_base_ff <= '0;
         wcol_ff     <= '0;
         v_ff        <= '0;
         u_ff        <= '0;
         chan_ff     <= '0;
         flat_ff     <= '0;
         dcnt_ff     <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         col_base_ff <= col_base_in;
         row_base_ff <= row_base_in;
         wcol_ff     <= wcol_in;
         v_ff        <= v_in;
         u_ff        <= u_in;
         chan_ff     <= chan_in;
         flat_ff     <= flat_in;
         dcnt_ff     <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dcol_sh_ff  <= dcol_sh_in;
      drow_sh_ff  <= drow_sh_in;
      drem_col_ff <= drem_col_in;
      drem_row_ff <= drem_row_in;
   end

   // line store: running max and index per window column
   logic [MEM_W-1:0] store_mem [MAX_COLS];
   logic [MEM_W-1:0] rd_data_ff, wr_data;
   logic             wr_en;

   // stage 1
   logic                          s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [INDEX_BITS-1:0]         s1_flat_ff;
   logic [CNT_W-1:0]              s1_addr_ff;
   logic                          s1_first_ff, s1_emit_ff, s1_last_ff;
   logic                          s1_fire, push;

   logic                          fwd_valid_ff;
   logic [CNT_W-1:0]              fwd_addr_ff;
   logic [MEM_W-1:0]              fwd_data_ff;

   logic [MEM_W-1:0]              old_word;
   logic signed [SAMPLE_BITS-1:0] old_val, new_val;
   logic [INDEX_BITS-1:0]         old_idx, new_idx;
   logic                          upd;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[s1_addr_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[wcol_ff];
      end
   end

   assign old_word = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : rd_data_ff;
   assign old_val  = signed'(old_word[MEM_W-1:INDEX_BITS]);
   assign old_idx  = old_word[INDEX_BITS-1:0];
   assign upd      = s1_first_ff || (s1_sample_ff > old_val);
   assign new_val  = upd ? s1_sample_ff : old_val;
   assign new_idx  = upd ? s1_flat_ff : old_idx;
   assign wr_data  = {new_val, new_idx};

   logic out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in, pop, out_take;
   logic signed [SAMPLE_BITS-1:0] out_val_ff, skid_val_ff;
   logic [INDEX_BITS-1:0]         out_idx_ff, skid_idx_ff;
   logic                          out_end_ff, skid_end_ff;

   assign stall   = s1_valid_ff && s1_emit_ff && out_valid_ff && skid_valid_ff;
   assign s1_fire = s1_valid_ff && !stall;
   assign wr_en   = s1_fire && upd;
   assign push    = s1_fire && s1_emit_ff;

   assign req_chan.ready = (state_ff == ST_RUN) && !csr_wr_en && !stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (rd_en) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (wr_en) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_sample_ff <= req_chan.sample;
         s1_flat_ff   <= flat_ff;
         s1_addr_ff   <= wcol_ff;
         s1_first_ff  <= first_s0;
         s1_emit_ff   <= emit_s0;
         s1_last_ff   <= last_s0;
      end
      if (wr_en) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= wr_data;
      end
   end

   // output register plus skid entry
   assign pop      = out_valid_ff && rsp_chan.ready;
   assign out_take = !out_valid_ff || pop;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            skid_valid_in = push;
         end else begin
            out_valid_in  = push;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         if (skid_valid_ff) begin
            out_val_ff <= skid_val_ff;
            out_idx_ff <= skid_idx_ff;
            out_end_ff <= skid_end_ff;
         end else begin
            out_val_ff <= new_val;
            out_idx_ff <= new_idx;
            out_end_ff <= s1_last_ff;
         end
      end
      if (push && (skid_valid_ff || !out_take)) begin
         skid_val_ff <= new_val;
         skid_idx_ff <= new_idx;
         skid_end_ff <= s1_last_ff;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.max_value = out_val_ff;
   assign rsp_chan.max_index = out_idx_ff;
   assign rsp_chan.frame_end = out_end_ff;

   a_col_align: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (col_ff == col_base_ff + CNT_W'(v_ff)))
      else $error("column window base out of step with column counter");

   a_row_align: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (row_ff == row_base_ff + CNT_W'(u_ff)))
      else $error("row window base out of step with row counter");

   a_v_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> ((v_ff < pc) && (u_ff < pr)))
      else $error("window offset beyond pool size");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !(out_valid_ff && skid_valid_ff))
      else $error("result pushed into full output buffer");

   a_div_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> !req_fire)
      else $error("request taken during counter realignment");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
module testbench;
   import mpas_pkg::*;

   typedef logic signed [DEF_SAMPLE_BITS-1:0] sample_type;
   typedef sample_type sample_list_type[$];

   typedef struct {
      sample_type                max_value;
      logic [DEF_INDEX_BITS-1:0] max_index;
      logic                      frame_end;
   } pool_window_type;

   typedef enum int {
      FLOW_STEADY,
      FLOW_SEND_GAPS,
      FLOW_RECV_STALLS,
      FLOW_BOTH
   } flow_type;

   class pool_tracker;
      logic [POOL_REG_W-1:0]     pool_rows_reg;
      logic [POOL_REG_W-1:0]     pool_cols_reg;
      logic [DIM_REG_W-1:0]      row_len_reg;
      logic [DIM_REG_W-1:0]      plane_rows_reg;
      logic [CHAN_REG_W-1:0]     plane_count_reg;
      sample_type                column_max [DEF_MAX_COLS];
      logic [DEF_INDEX_BITS-1:0] column_arg [DEF_MAX_COLS];
      int unsigned               col_pos;
      int unsigned               row_pos;
      int unsigned               plane_pos;
      logic [DEF_INDEX_BITS-1:0] flat_pos;
      pool_window_type           pending_windows[$];
      int unsigned               errors;
      int unsigned               windows_seen;
      int unsigned               frames_seen;
      int unsigned               samples_seen;

      function void clear();
         pool_rows_reg   = RST_POOL;
         pool_cols_reg   = RST_POOL;
         row_len_reg     = RST_DIM;
         plane_rows_reg  = RST_DIM;
         plane_count_reg = RST_CHAN;
         col_pos         = 0;
         row_pos         = 0;
         plane_pos       = 0;
         flat_pos        = '0;
         errors          = 0;
         windows_seen    = 0;
         frames_seen     = 0;
         samples_seen    = 0;
         pending_windows.delete();
      endfunction

      function int unsigned limit(int unsigned v, int unsigned hi);
         if (v == 0) return 1;
         return (v > hi) ? hi : v;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_POOL_ROWS:        pool_rows_reg   = data[POOL_REG_W-1:0];
            CSR_POOL_COLS:        pool_cols_reg   = data[POOL_REG_W-1:0];
            CSR_COLS_PER_ROW:     row_len_reg     = data[DIM_REG_W-1:0];
            CSR_ROWS_PER_CHANNEL: plane_rows_reg  = data[DIM_REG_W-1:0];
            CSR_CHANNEL_COUNT:    plane_count_reg = data[CHAN_REG_W-1:0];
            default: ;
         endcase
      endfunction

      function void take_sample(sample_type s);
         int unsigned     pr;
         int unsigned     pc;
         int unsigned     nc;
         int unsigned     nr;
         int unsigned     nch;
         int unsigned     wc;
         int unsigned     wr;
         int unsigned     u;
         int unsigned     v;
         pool_window_type w;
         pr  = limit(pool_rows_reg, DEF_MAX_POOL);
         pc  = limit(pool_cols_reg, DEF_MAX_POOL);
         nc  = limit(row_len_reg, DEF_MAX_COLS);
         nr  = limit(plane_rows_reg, DEF_MAX_COLS);
         nch = limit(plane_count_reg, MAX_CHANNELS);
         wc  = col_pos / pc;
         wr  = row_pos / pr;
         u   = row_pos % pr;
         v   = col_pos % pc;
         samples_seen++;
         if (wc < nc / pc && wr < nr / pr) begin
            if ((u == 0 && v == 0) || s > column_max[wc]) begin
               column_max[wc] = s;
               column_arg[wc] = flat_pos;
            end
            if (u == pr - 1 && v == pc - 1) begin
               w.max_value = column_max[wc];
               w.max_index = column_arg[wc];
               w.frame_end = (plane_pos == nch - 1) && (wr == nr / pr - 1) &&
                             (wc == nc / pc - 1);
               pending_windows.push_back(w);
            end
         end
         flat_pos = flat_pos + 1'b1;
         if (col_pos + 1 >= nc) begin
            col_pos = 0;
            if (row_pos + 1 >= nr) begin
               row_pos = 0;
               if (plane_pos + 1 >= nch) begin
                  plane_pos = 0;
                  flat_pos  = '0;
               end else begin
                  plane_pos++;
               end
            end else begin
               row_pos++;
            end
         end else begin
            col_pos++;
         end
      endfunction

      function void match_result(sample_type value, logic [DEF_INDEX_BITS-1:0] index,
                                 logic last);
         pool_window_type w;
         windows_seen++;
         if (last === 1'b1) frames_seen++;
         if (pending_windows.size() == 0) begin
            errors++;
            $display("%0t: unexpected result value %0d index %0d frame_end %b",
                     $time, value, index, last);
            return;
         end
         w = pending_windows.pop_front();
         if (value !== w.max_value) begin
            errors++;
            $display("%0t: max_value expected %0d got %0d", $time, w.max_value, value);
         end
         if (index !== w.max_index) begin
            errors++;
            $display("%0t: max_index expected %0d got %0d", $time, w.max_index, index);
         end
         if (last !== w.frame_end) begin
            errors++;
            $display("%0t: frame_end expected %b got %b", $time, w.frame_end, last);
         end
      endfunction
   endclass

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 250;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_wr_en;
   csr_index_type           csr_index;
   logic [CSR_DATA_W-1:0]   csr_wr_data;
   int unsigned             sender_idle_pct;
   int unsigned             receiver_stall_pct;
   int unsigned             phase_count;
   pool_tracker             tracker;

   mpas_req_if req_link ();
   mpas_rsp_if rsp_link ();

   max_pool_argmax_stream_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_link),
      .rsp_chan    (rsp_link),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_link.ready = ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_link.valid && rsp_link.ready) begin
         tracker.match_result(rsp_link.max_value, rsp_link.max_index, rsp_link.frame_end);
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("max_pool_argmax_stream_unit: mismatch");
      $finish;
   end

   function automatic sample_type random_sample();
      case ($urandom_range(3))
         0:       return sample_type'($urandom_range(4)) - sample_type'(2);
         1:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic sample_list_type random_samples(int unsigned n);
      sample_list_type list;
      repeat (n) list.push_back(random_sample());
      return list;
   endfunction

   function automatic int unsigned frame_length(int unsigned nc, int unsigned nr,
                                                int unsigned nch);
      return tracker.limit(nc, DEF_MAX_COLS) * tracker.limit(nr, DEF_MAX_COLS) *
             tracker.limit(nch, MAX_CHANNELS);
   endfunction

   task automatic settle();
      @(negedge clock);
      req_link.valid = 1'b0;
      while (tracker.pending_windows.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(csr_index_type idx, int unsigned value);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = value[CSR_DATA_W-1:0];
      tracker.write_register(idx, value[CSR_DATA_W-1:0]);
   endtask

   task automatic send_sample(sample_type s);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_link.valid = 1'b0;
         @(negedge clock);
      end
      req_link.valid  = 1'b1;
      req_link.sample = s;
      @(posedge clock);
      while (!req_link.ready) @(posedge clock);
      tracker.take_sample(s);
   endtask

   task automatic run_phase(int unsigned pr, int unsigned pc, int unsigned nc,
                            int unsigned nr, int unsigned nch, sample_list_type samples);
      flow_type flow;
      settle();
      flow = flow_type'(phase_count % 4);
      phase_count++;
      case (flow)
         FLOW_STEADY: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         FLOW_SEND_GAPS: begin
            sender_idle_pct    = 82;
            receiver_stall_pct = 0;
         end
         FLOW_RECV_STALLS: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 82;
         end
         default: begin
            sender_idle_pct    = 23;
            receiver_stall_pct = 23;
         end
      endcase
      write_register(CSR_POOL_ROWS, pr);
      write_register(CSR_POOL_COLS, pc);
      write_register(CSR_COLS_PER_ROW, nc);
      write_register(CSR_ROWS_PER_CHANNEL, nr);
      write_register(CSR_CHANNEL_COUNT, nch);
      @(negedge clock);
      csr_wr_en = 1'b0;
      foreach (samples[i]) send_sample(samples[i]);
   endtask

   initial begin : stimulus
      sample_list_type list;
      int unsigned     random_sent;
      int unsigned     pr;
      int unsigned     pc;
      int unsigned     nc;
      int unsigned     nr;
      int unsigned     nch;
      int unsigned     len;
      tracker = new();
      tracker.clear();
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_POOL_ROWS;
      csr_wr_data        = '0;
      req_link.valid     = 1'b0;
      req_link.sample    = '0;
      rsp_link.ready     = 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      phase_count        = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // all-minimum window ties to its first sample, maximum tie goes to the earlier one
      list = '{16'sh8000, 16'sh8000, 16'sh0005, 16'sh7fff,
               16'sh8000, 16'sh8000, 16'sh7fff, -16'sh0001};
      run_phase(2, 2, 4, 2, 1, list);
      // pool wider than the row: zero registers read as one, nothing comes out
      list = '{16'sh0000, -16'sh0001, 16'sh5555};
      run_phase(0, 5, 3, 0, 0, list);
      // leftover column and row are only counted
      list = '{16'sh0100, 16'sh0200, 16'sh7fff, 16'sh0200, -16'sh0100,
               16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh2aaa};
      run_phase(2, 2, 3, 3, 1, list);

      // geometry extremes, saturated register values among them
      run_phase(31, 1, 1, 40, 1, random_samples(40));
      run_phase(1, 31, 40, 1, 1, random_samples(40));
      run_phase(0, 1, 1, 1, 511, random_samples(256));
      run_phase(16, 16, 16, 16, 1, random_samples(256));

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         pr  = ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(1, 4);
         pc  = ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(1, 4);
         nc  = $urandom_range(12);
         nr  = $urandom_range(8);
         nch = $urandom_range(3);
         len = frame_length(nc, nr, nch);
         len = len * (1 + 60 / len);
         run_phase(pr, pc, nc, nr, nch, random_samples(len));
         random_sent += len;
      end

      settle();
      if (tracker.pending_windows.size() != 0) begin
         tracker.errors++;
         $display("%0t: %0d windows never came out", $time, tracker.pending_windows.size());
      end
      $display("%0d samples over %0d pool geometries", tracker.samples_seen, phase_count);
      $display("%0d windows compared, %0d of them closing a frame, %0d errors",
               tracker.windows_seen, tracker.frames_seen, tracker.errors);
      if (tracker.errors == 0) begin
         $display("max_pool_argmax_stream_unit: match");
      end else begin
         $display("max_pool_argmax_stream_unit: mismatch");
      end
      $finish;
   end

endmodule
